// File: design/sscheck_pkg.sv
package sscheck_pkg;

  localparam int VALUE_W = 11;
  localparam int VERDICT_W = 2;
  localparam int MAX_LEN_DEF = 1024;

  localparam logic [VERDICT_W-1:0] VERDICT_SORTABLE = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_NOT_SORTABLE = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_TOO_LONG = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_CHECK
  } state_t;

endpackage

// File: design/stack_sortable_check.sv
// Checks whether a permutation of 1..N can be sorted with a single stack. Values arrive one per
// input transaction; the transaction with last set returns one verdict (sortable, not sortable,
// or too long when more than MAX_LEN values came) and clears the state for the next array. The
// stack lives in a MAX_LEN-entry synchronous memory, with the top cached in a register. An
// input transaction is taken in the idle state; the check state then pops the stack while the
// top is the next value due, reading each new top from memory, and at last pushes the value or
// marks a failure. Every value is popped at most once. A verdict waits in an output register,
// and the next value is taken while it waits. If that value is also marked last, it holds until
// the output register is free. Out of reset the block is ready at once: there is no clearing pass.
module stack_sortable_check #(
  parameter int MAX_LEN = sscheck_pkg::MAX_LEN_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [sscheck_pkg::VALUE_W-1:0]   value,
  input  logic                              last,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [sscheck_pkg::VERDICT_W-1:0] verdict
);

  localparam int VW = sscheck_pkg::VALUE_W;
  localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam int ITEM_W = $clog2(MAX_LEN + 2);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_LEN);
  localparam logic [ITEM_W-1:0] ITEM_SAT = ITEM_W'(MAX_LEN + 1);

  sscheck_pkg::state_t state, state_next;

  logic [CNT_W-1:0]  count, count_next;
  logic [VW-1:0]     emitted, emitted_next;
  logic              failed, failed_next;
  logic [ITEM_W-1:0] item_count, item_count_next;
  logic              too_long, too_long_next;
  logic [VW-1:0]     cur_value, cur_value_next;
  logic              cur_last, cur_last_next;
  logic [VW-1:0]     top, top_next;
  logic              top_fresh, top_fresh_next;
  logic              out_valid_next;
  logic [sscheck_pkg::VERDICT_W-1:0] verdict_next;

  logic [VW-1:0]     stack_mem [MAX_LEN];
  logic [VW-1:0]     rd_data;
  logic              rd_en, wr_en;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic [VW-1:0]     wr_data;

  logic [VW-1:0] top_cur;
  logic          active, pop, can_finish, fail_now;
  logic [CNT_W-1:0] count_m2;

  assign in_stall = (state != sscheck_pkg::ST_IDLE);
  assign top_cur = top_fresh ? rd_data : top;
  assign count_m2 = count - CNT_W'(2);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= stack_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sscheck_pkg::ST_IDLE;
      count <= '0;
      emitted <= '0;
      failed <= 1'b0;
      item_count <= '0;
      too_long <= 1'b0;
      top_fresh <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      emitted <= emitted_next;
      failed <= failed_next;
      item_count <= item_count_next;
      too_long <= too_long_next;
      top_fresh <= top_fresh_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_value <= cur_value_next;
    cur_last <= cur_last_next;
    top <= top_next;
    verdict <= verdict_next;
  end

  always_comb begin
    state_next = state;
    count_next = count;
    emitted_next = emitted;
    failed_next = failed;
    item_count_next = item_count;
    too_long_next = too_long;
    cur_value_next = cur_value;
    cur_last_next = cur_last;
    top_next = top;
    top_fresh_next = top_fresh;
    verdict_next = verdict;
    out_valid_next = out_valid && out_stall;
    rd_en = 1'b0;
    rd_addr = count_m2[ADDR_W-1:0];
    wr_en = 1'b0;
    wr_addr = count[ADDR_W-1:0];
    wr_data = cur_value;
    active = !too_long && !failed;
    pop = active && (count != '0) &&
          ({1'b0, top_cur} == ({1'b0, emitted} + (VW+1)'(1)));
    can_finish = !cur_last || !out_valid || !out_stall;
    fail_now = failed;

    case (state)
      sscheck_pkg::ST_IDLE: begin
        if (in_valid) begin
          cur_value_next = value;
          cur_last_next = last;
          if (item_count != ITEM_SAT) begin
            item_count_next = item_count + ITEM_W'(1);
          end
          if (too_long || (item_count_next == ITEM_SAT)) begin
            too_long_next = 1'b1;
          end
          state_next = sscheck_pkg::ST_CHECK;
        end
      end
      sscheck_pkg::ST_CHECK: begin
        if (pop) begin
          emitted_next = emitted + VW'(1);
          count_next = count - CNT_W'(1);
          rd_en = (count != CNT_W'(1));
          top_fresh_next = 1'b1;
        end else if (can_finish) begin
          if (active) begin
            if (count == '0 || (count != CNT_FULL && cur_value < top_cur)) begin
              wr_en = 1'b1;
              count_next = count + CNT_W'(1);
              top_next = cur_value;
              top_fresh_next = 1'b0;
            end else begin
              fail_now = 1'b1;
              failed_next = 1'b1;
            end
          end
          if (cur_last) begin
            out_valid_next = 1'b1;
            if (too_long) begin
              verdict_next = sscheck_pkg::VERDICT_TOO_LONG;
            end else if (fail_now) begin
              verdict_next = sscheck_pkg::VERDICT_NOT_SORTABLE;
            end else begin
              verdict_next = sscheck_pkg::VERDICT_SORTABLE;
            end
            count_next = '0;
            emitted_next = '0;
            failed_next = 1'b0;
            item_count_next = '0;
            too_long_next = 1'b0;
            top_fresh_next = 1'b0;
          end
          state_next = sscheck_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sscheck_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: design/sscheck_checker.sv
module sscheck_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [sscheck_pkg::VERDICT_W-1:0] verdict
);

  // no verdict comes out of reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("verdict valid right after reset");

  // a held verdict keeps its value
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(verdict))
    else $error("stalled verdict changed");

  // only the three defined codes
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (verdict == sscheck_pkg::VERDICT_SORTABLE ||
                   verdict == sscheck_pkg::VERDICT_NOT_SORTABLE ||
                   verdict == sscheck_pkg::VERDICT_TOO_LONG))
    else $error("undefined verdict code");

  // each value is worked on before the next is taken
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken on consecutive cycles");

  // a new verdict only appears after the block was busy
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("verdict without a finished transaction");

endmodule

bind stack_sortable_check sscheck_checker u_sscheck_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .verdict   (verdict)
);

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int STACK_DEPTH = sscheck_pkg::MAX_LEN_DEF;
  localparam int STUCK_LIMIT = 5000;
  localparam int RANDOM_ITEMS = 550;
  localparam int N_PROBE = 22;

  typedef struct packed {
    logic [sscheck_pkg::VALUE_W-1:0]   val;
    logic                              fin;
    logic                              typed;
    logic [sscheck_pkg::VERDICT_W-1:0] want;
  } probe_row_t;

  logic                              clk;
  logic                              rst = 1'b1;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic [sscheck_pkg::VALUE_W-1:0]   value = '0;
  logic                              last = 1'b0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic [sscheck_pkg::VERDICT_W-1:0] verdict;

  stack_sortable_check #(
    .MAX_LEN(STACK_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .value(value),
    .last(last),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .verdict(verdict)
  );

  // directed arrays: single extremes, the 231 pattern, pops, items after failure,
  // repeated and out-of-range values, back-to-back verdicts
  probe_row_t probe_tab [N_PROBE] = '{
    '{11'd1024, 1'b1, 1'b1, sscheck_pkg::VERDICT_SORTABLE},
    '{11'd1,    1'b1, 1'b1, sscheck_pkg::VERDICT_SORTABLE},
    '{11'd2,    1'b0, 1'b0, sscheck_pkg::VERDICT_SORTABLE},
    '{11'd3,    1'b0, 1'b0, sscheck_pkg::VERDICT_SORTABLE},
    '{11'd1,    1'b1, 1'b1, sscheck_pkg::VERDICT_NOT_SORTABLE},
    '{11'd3,    1'b0, 1'b0, sscheck_pkg::VERDICT_SORTABLE},
    '{11'd1,    1'b0, 1'b0, sscheck_pkg::VERDICT_SORTABLE},
    '{11'd2,    1'b1, 1'b0, sscheck_pkg::VERDICT_SORTABLE},
    '{11'd2,    1'b0, 1'b0, sscheck_pkg::VERDICT_SORTABLE},
    '{11'd1,    1'b0, 1'b0, sscheck_pkg::VERDICT_SORTABLE},
    '{11'd3,    1'b1, 1'b0, sscheck_pkg::VERDICT_SORTABLE},
    '{11'd2,    1'b0, 1'b0, sscheck_pkg::VERDICT_SORTABLE},
    '{11'd3,    1'b0, 1'b0, sscheck_pkg::VERDICT_SORTABLE},
    '{11'd1,    1'b0, 1'b0, sscheck_pkg::VERDICT_SORTABLE},
    '{11'd5,    1'b0, 1'b0, sscheck_pkg::VERDICT_SORTABLE},
    '{11'd4,    1'b1, 1'b1, sscheck_pkg::VERDICT_NOT_SORTABLE},
    '{11'd1,    1'b0, 1'b0, sscheck_pkg::VERDICT_SORTABLE},
    '{11'd1,    1'b1, 1'b0, sscheck_pkg::VERDICT_SORTABLE},
    '{11'd1024, 1'b0, 1'b0, sscheck_pkg::VERDICT_SORTABLE},
    '{11'd1023, 1'b0, 1'b0, sscheck_pkg::VERDICT_SORTABLE},
    '{11'd7,    1'b1, 1'b0, sscheck_pkg::VERDICT_SORTABLE},
    '{11'd1,    1'b1, 1'b1, sscheck_pkg::VERDICT_SORTABLE}
  };

  // checker state
  logic [sscheck_pkg::VALUE_W-1:0] sort_stack [STACK_DEPTH];
  int sort_depth = 0;
  int next_due = 0;
  int seen_items = 0;
  bit hit_fail = 1'b0;
  bit overlong = 1'b0;

  logic [sscheck_pkg::VERDICT_W-1:0] pending_verdicts [$];
  logic [sscheck_pkg::VERDICT_W-1:0] due_verdict;
  int perm [$];
  int errors = 0;
  int stuck_cycles = 0;
  int burst_left = 0;
  int gap_max = 4;
  int stall_pct = 0;
  int stall_max = 1;
  int hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void step_checker(input logic [sscheck_pkg::VALUE_W-1:0] v,
                                       input logic fin, output logic done,
                                       output logic [sscheck_pkg::VERDICT_W-1:0] vd);
    if (seen_items <= STACK_DEPTH) seen_items++;
    if (seen_items > STACK_DEPTH) overlong = 1'b1;
    if (!overlong && !hit_fail) begin
      while (sort_depth > 0 && int'(sort_stack[sort_depth-1]) == next_due + 1) begin
        next_due++;
        sort_depth--;
      end
      if (sort_depth == 0) begin
        sort_stack[0] = v;
        sort_depth = 1;
      end else if (sort_depth < STACK_DEPTH && v < sort_stack[sort_depth-1]) begin
        sort_stack[sort_depth] = v;
        sort_depth++;
      end else begin
        hit_fail = 1'b1;
      end
    end
    done = fin;
    if (overlong) vd = sscheck_pkg::VERDICT_TOO_LONG;
    else if (hit_fail) vd = sscheck_pkg::VERDICT_NOT_SORTABLE;
    else vd = sscheck_pkg::VERDICT_SORTABLE;
    if (fin) begin
      sort_depth = 0;
      next_due = 0;
      seen_items = 0;
      hit_fail = 1'b0;
      overlong = 1'b0;
    end
  endfunction

  // a stack-sortable layout is alpha, max, beta with every alpha value below every beta value
  function automatic void fill_sortable(input int n);
    int seg_pos [$];
    int seg_lo [$];
    int seg_hi [$];
    int p, lo, hi, k;
    perm.delete();
    for (int i = 0; i < n; i++) perm.push_back(0);
    seg_pos.push_back(0);
    seg_lo.push_back(1);
    seg_hi.push_back(n);
    while (seg_pos.size() > 0) begin
      p = seg_pos.pop_back();
      lo = seg_lo.pop_back();
      hi = seg_hi.pop_back();
      if (hi >= lo) begin
        k = $urandom_range(0, hi - lo);
        perm[p+k] = hi;
        seg_pos.push_back(p);
        seg_lo.push_back(lo);
        seg_hi.push_back(lo + k - 1);
        seg_pos.push_back(p + k + 1);
        seg_lo.push_back(lo + k);
        seg_hi.push_back(hi - 1);
      end
    end
  endfunction

  function automatic void fill_shuffled(input int n);
    int j, t;
    perm.delete();
    for (int i = 1; i <= n; i++) perm.push_back(i);
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = perm[i];
      perm[i] = perm[j];
      perm[j] = t;
    end
  endfunction

  function automatic void fill_noise(input int n);
    perm.delete();
    for (int i = 0; i < n; i++) perm.push_back($urandom_range(1, 1024));
  endfunction

  function automatic void spoil_perm();
    int a, b, t;
    a = $urandom_range(0, perm.size() - 1);
    b = $urandom_range(0, perm.size() - 1);
    if ($urandom_range(0, 1) == 0) begin
      t = perm[a];
      perm[a] = perm[b];
      perm[b] = t;
    end else begin
      perm[a] = perm[b];
    end
  endfunction

  task automatic send_item(input logic [sscheck_pkg::VALUE_W-1:0] v, input logic fin,
                           input logic typed,
                           input logic [sscheck_pkg::VERDICT_W-1:0] want);
    int gap;
    logic done;
    logic [sscheck_pkg::VERDICT_W-1:0] vd;
    if (burst_left == 0) begin
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_valid <= 1'b1;
    value <= v;
    last <= fin;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    step_checker(v, fin, done, vd);
    if (done) pending_verdicts.push_back(typed ? want : vd);
    @(posedge clk);
    burst_left--;
  endtask

  task automatic send_perm();
    for (int i = 0; i < perm.size(); i++)
      send_item(perm[i][sscheck_pkg::VALUE_W-1:0], i == perm.size() - 1, 1'b0,
                sscheck_pkg::VERDICT_SORTABLE);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_verdicts.size() > 0) @(posedge clk);
  endtask

  task automatic pick_pacing();
    int mode;
    gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
    mode = $urandom_range(0, 2);
    stall_pct = (mode == 0) ? 0 : (mode == 1) ? 20 : 40;
    stall_max = (mode == 2) ? 20 : 3;
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      out_stall <= 1'b1;
      hold_left = $urandom_range(0, stall_max - 1);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // output transaction check, sampled mid-cycle ahead of the accepting edge
  always @(negedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: verdict %0d with none expected", $time, verdict);
        errors++;
      end else begin
        due_verdict = pending_verdicts.pop_front();
        if (verdict !== due_verdict) begin
          $display("%0t: verdict mismatch, expected %0d, actual %0d",
                   $time, due_verdict, verdict);
          errors++;
        end
      end
    end
  end

  initial begin
    while (stuck_cycles < STUCK_LIMIT) begin
      @(negedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cycles = 0;
      else stuck_cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int rand_items;
    int kind;
    int n;
    rand_items = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_PROBE; i++)
      send_item(probe_tab[i].val, probe_tab[i].fin, probe_tab[i].typed, probe_tab[i].want);
    drain_results();

    while (rand_items < RANDOM_ITEMS) begin
      pick_pacing();
      kind = $urandom_range(0, 9);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
      if (kind < 6) begin
        fill_sortable(n);
      end else if (kind < 8) begin
        fill_shuffled(n);
      end else if (kind == 8) begin
        fill_noise(n);
      end else begin
        fill_sortable(n);
        spoil_perm();
      end
      send_perm();
      rand_items += n;
      if ($urandom_range(0, 15) == 0) drain_results();
    end

    // deep stack popped in one go, then a failure, then one transaction over the length
    pick_pacing();
    perm.delete();
    for (int i = STACK_DEPTH - 2; i >= 1; i--) perm.push_back(i);
    perm.push_back(STACK_DEPTH);
    perm.push_back(2000);
    perm.push_back(7);
    send_perm();

    drain_results();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: sim.f
design/sscheck_pkg.sv
design/stack_sortable_check.sv
design/sscheck_checker.sv
dv/tb.sv
